// ===== hw/rtl/lcc_pkg.sv =====
package lcc_pkg;

   localparam int DEF_CAPACITY = 32;

   localparam int KEY_W   = 64;
   localparam int COST_W  = 3;
   localparam int TOTAL_W = 32;
   localparam int OCC_W   = 6;
   localparam int CFG_W   = 6;

   localparam logic [COST_W-1:0] COST_HIT  = 3'd1;
   localparam logic [COST_W-1:0] COST_MISS = 3'd5;

   // lookup outcome handed from the tag store to the response stage
   typedef struct packed {
      logic             hit;
      logic [OCC_W-1:0] occupancy;
   } lookup_type;

endpackage

// ===== hw/rtl/lcc_req_if.sv =====
interface lcc_req_if;
   import lcc_pkg::*;

   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

// ===== hw/rtl/lcc_rsp_if.sv =====
interface lcc_rsp_if;
   import lcc_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [COST_W-1:0]  cost;
   logic [TOTAL_W-1:0] running_total;
   logic [OCC_W-1:0]   occupancy;

   modport source (output valid, output hit, output cost, output running_total,
                   output occupancy, input ready);
   modport sink   (input valid, input hit, input cost, input running_total,
                   input occupancy, output ready);
endinterface

// ===== hw/rtl/lcc_tag_store.sv =====
module lcc_tag_store #(
   parameter int CAPACITY = lcc_pkg::DEF_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lcc_pkg::CFG_W-1:0] active_entries,
   input  logic [lcc_pkg::KEY_W-1:0] key,
   input  logic                      update,
   output lcc_pkg::lookup_type       lookup
);
   import lcc_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SZ_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // slot 0 is most recently used, slot count_ff-1 least recently used
   logic [KEY_W-1:0] tags_ff [CAPACITY];
   logic [KEY_W-1:0] tags_in [CAPACITY];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic [SZ_W-1:0]     size;
   logic [SZ_W-1:0]     count_ext;
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] shift;
   logic                enabled;
   logic                hit;
   logic [CNT_W-1:0]    count_next;

   always_comb begin
      size = (SZ_W'(active_entries) > SZ_W'(CAPACITY)) ? SZ_W'(CAPACITY)
                                                       : SZ_W'(active_entries);
      count_ext = SZ_W'(count_ff);
      enabled   = (size != '0);
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (tags_ff[i] == key) && (CNT_W'(i) < count_ff);
      end
   end

   assign hit = enabled && (|match);

   // a slot takes its upper neighbor when the match sits at or below it in recency
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         shift[i] = !hit || (|(match >> i));
      end
      tags_in[0] = key;
      for (int i = 1; i < CAPACITY; i++) begin
         tags_in[i] = shift[i] ? tags_ff[i-1] : tags_ff[i];
      end
   end

   // miss trims the LRU tail so the new key fits within the size
   always_comb begin
      if (hit) begin
         count_next = count_ff;
      end else if (count_ext >= size) begin
         count_next = CNT_W'(size);
      end else begin
         count_next = count_ff + CNT_W'(1);
      end
      count_in = (update && enabled) ? count_next : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update && enabled) begin
         for (int i = 0; i < CAPACITY; i++) begin
            tags_ff[i] <= tags_in[i];
         end
      end
   end

   assign lookup.hit       = hit;
   assign lookup.occupancy = enabled ? OCC_W'(count_next) : OCC_W'(count_ff);

endmodule

// ===== hw/rtl/lcc_rsp_stage.sv =====
module lcc_rsp_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lcc_pkg::lookup_type lookup,
   lcc_rsp_if.source           rsp_if
);
   import lcc_pkg::*;

   logic               valid_ff, valid_in;
   logic [TOTAL_W-1:0] sum_ff, sum_in;
   logic               hit_ff;
   logic [COST_W-1:0]  cost_ff, cost_in;
   logic [OCC_W-1:0]   occ_ff;
   logic [TOTAL_W:0]   sum_wide;
   logic               load;

   assign in_ready = !valid_ff || rsp_if.ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      cost_in  = lookup.hit ? COST_HIT : COST_MISS;
      sum_wide = {1'b0, sum_ff} + (TOTAL_W + 1)'(cost_in);
      // saturate at all ones
      sum_in   = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff  <= lookup.hit;
         cost_ff <= cost_in;
         occ_ff  <= lookup.occupancy;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.hit           = hit_ff;
   assign rsp_if.cost          = cost_ff;
   assign rsp_if.running_total = sum_ff;
   assign rsp_if.occupancy     = occ_ff;

endmodule

// ===== hw/rtl/lru_cache_hit_cost_core.sv =====
// Channel  Dir  Beat contents                              Handshake
// req_if   in   key[63:0]                                  valid/ready
// rsp_if   out  hit, cost[2:0], running_total[31:0],       valid/ready
//               occupancy[5:0]
// csr      in   active_entries[5:0]                        csr_we, no ready
//
// One access per cycle sustained while rsp_if is ready; a beat taken
// on req_if passes the input register, then the result register, before
// it shows on rsp_if. The access rate is set by the parallel tag compare
// and one-slot recency shift across all CAPACITY entries, combinationally.
// Synchronous active-high reset clears occupancy, running total, size and
// both valid flags; tag contents are not reset.
// A stall on rsp_if holds the result register; the input register still
// takes one more beat if empty, then req_if.ready drops until rsp_if drains.
module lru_cache_hit_cost_core #(
   parameter int CAPACITY = lcc_pkg::DEF_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   lcc_req_if.sink                   req_if,
   lcc_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic [lcc_pkg::CFG_W-1:0] csr_wdata
);
   import lcc_pkg::*;

   // size register; to be written only while idle, not enforced by the block
   logic [CFG_W-1:0] active_ff;

   // input register
   logic             stage_valid_ff, stage_valid_in;
   logic [KEY_W-1:0] key_ff;

   logic       rsp_in_ready;
   logic       advance;
   logic       req_take;
   lookup_type lookup;

   assign advance       = stage_valid_ff && rsp_in_ready;
   assign req_if.ready  = !stage_valid_ff || rsp_in_ready;
   assign req_take      = req_if.valid && req_if.ready;

   always_comb begin
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         active_ff      <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff <= req_if.key;
      end
   end

   // tag state commits on the same edge the result register loads, so the
   // next beat in the input register sees the updated recency order
   lcc_tag_store #(
      .CAPACITY (CAPACITY)
   ) u_tag_store (
      .clock          (clock),
      .reset          (reset),
      .active_entries (active_ff),
      .key            (key_ff),
      .update         (advance),
      .lookup         (lookup)
   );

   lcc_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid_ff),
      .in_ready (rsp_in_ready),
      .lookup   (lookup),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== hw/rtl/lcc_checker.sv =====
module lcc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic [lcc_pkg::COST_W-1:0]  rsp_cost,
   input logic [lcc_pkg::TOTAL_W-1:0] rsp_total,
   input logic [lcc_pkg::OCC_W-1:0]   rsp_occupancy
);
   import lcc_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total)
                                  && $stable(rsp_hit) && $stable(rsp_cost)
                                  && $stable(rsp_occupancy))
      else $error("rsp beat changed under stall");

   a_cost_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit ? (rsp_cost == COST_HIT) : (rsp_cost == COST_MISS)))
      else $error("cost does not match hit");

   a_hit_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_occupancy != '0)
      else $error("hit with empty cache");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid || (rsp_total >= $past(rsp_total)))
      else $error("running total went down");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind lru_cache_hit_cost_core lcc_checker u_lcc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_hit       (rsp_if.hit),
   .rsp_cost      (rsp_if.cost),
   .rsp_total     (rsp_if.running_total),
   .rsp_occupancy (rsp_if.occupancy)
);

// ===== tb/lru_cache_hit_cost_core_checker.sv =====
// Watches the request, response and csr ports, keeps its own copy of the
// LRU tag list, occupancy and running total, and compares every response
// beat against the oldest expected one.
module lru_cache_hit_cost_core_checker #(
   parameter int CAPACITY = lcc_pkg::DEF_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [lcc_pkg::KEY_W-1:0]   req_key,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_hit,
   input  logic [lcc_pkg::COST_W-1:0]  rsp_cost,
   input  logic [lcc_pkg::TOTAL_W-1:0] rsp_running_total,
   input  logic [lcc_pkg::OCC_W-1:0]   rsp_occupancy,
   input  logic                        csr_we,
   input  logic [lcc_pkg::CFG_W-1:0]   csr_wdata,
   output int                          fail_count,
   output int                          pending
);
   import lcc_pkg::*;

   typedef struct packed {
      logic               hit;
      logic [COST_W-1:0]  cost;
      logic [TOTAL_W-1:0] running_total;
      logic [OCC_W-1:0]   occupancy;
   } access_result_type;

   // slot 0 is least recently used, slot valid_cnt-1 most recently used
   logic [KEY_W-1:0]   lru_tags [CAPACITY];
   int                 valid_cnt;
   logic [TOTAL_W-1:0] cost_total;
   logic [CFG_W-1:0]   size_reg;
   access_result_type  result_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic remove_tag(input int pos);
      for (int i = pos; i + 1 < valid_cnt; i++)
         lru_tags[i] = lru_tags[i + 1];
      valid_cnt--;
   endtask

   task automatic lookup_key(input logic [KEY_W-1:0] key,
                             output access_result_type res);
      int                lim;
      int                found;
      logic [COST_W-1:0] c;
      lim   = (size_reg > CAPACITY) ? CAPACITY : int'(size_reg);
      found = -1;
      if (lim != 0) begin
         for (int i = 0; i < valid_cnt; i++)
            if (found < 0 && lru_tags[i] == key)
               found = i;
         if (found >= 0)
            remove_tag(found);
         else
            while (valid_cnt >= lim && valid_cnt > 0)
               remove_tag(0);
         if (valid_cnt < CAPACITY) begin
            lru_tags[valid_cnt] = key;
            valid_cnt++;
         end
      end
      c = (found >= 0) ? COST_HIT : COST_MISS;
      if (cost_total > {TOTAL_W{1'b1}} - TOTAL_W'(c))
         cost_total = {TOTAL_W{1'b1}};
      else
         cost_total = cost_total + TOTAL_W'(c);
      res.hit           = (found >= 0);
      res.cost          = c;
      res.running_total = cost_total;
      res.occupancy     = OCC_W'(valid_cnt);
   endtask

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      access_result_type res;
      if (reset) begin
         valid_cnt  = 0;
         cost_total = '0;
         size_reg   = '0;
         result_q.delete();
      end else begin
         if (csr_we)
            size_reg = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected response beat, hit %0d cost %0d total %0d occ %0d",
                        $time, rsp_hit, rsp_cost, rsp_running_total, rsp_occupancy);
               fail_count++;
            end else begin
               res = result_q.pop_front();
               compare_field("hit", 64'(res.hit), 64'(rsp_hit));
               compare_field("cost", 64'(res.cost), 64'(rsp_cost));
               compare_field("running_total", 64'(res.running_total),
                             64'(rsp_running_total));
               compare_field("occupancy", 64'(res.occupancy), 64'(rsp_occupancy));
            end
         end
         if (req_valid && req_ready) begin
            lookup_key(req_key, res);
            result_q.insert(result_q.size(), res);
         end
      end
      pending = result_q.size();
   end

endmodule

// ===== tb/lru_cache_hit_cost_core_tb.sv =====
module lru_cache_hit_cost_core_tb;
   import lcc_pkg::*;

   // stimulus sizing
   localparam int RAND_ITEMS = 1900;
   localparam int CALM_ITEMS = 300;  // tail of the run with no idling
   localparam int POOL_SIZE  = 40;   // keys reused so hits are common
   localparam int DRAIN_GAP  = 4;    // two-stage pipe plus margin

   // size settings of interest
   localparam logic [CFG_W-1:0] SIZE_OFF  = 6'd0;
   localparam logic [CFG_W-1:0] SIZE_ONE  = 6'd1;
   localparam logic [CFG_W-1:0] SIZE_FULL = 6'd32;
   localparam logic [CFG_W-1:0] SIZE_OVER = 6'd33;
   localparam logic [CFG_W-1:0] SIZE_TOP  = 6'd63;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;
   logic             idle_en;   // gates both sender gaps and receiver stalls
   int               stall_left;
   int               fail_count;
   int               pending;

   lcc_req_if req_if ();
   lcc_rsp_if rsp_if ();

   lru_cache_hit_cost_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lru_cache_hit_cost_core_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_key           (req_if.key),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_hit           (rsp_if.hit),
      .rsp_cost          (rsp_if.cost),
      .rsp_running_total (rsp_if.running_total),
      .rsp_occupancy     (rsp_if.occupancy),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Everything the block sees is known from time zero.
   initial begin
      req_if.valid  = 1'b0;
      req_if.key    = '0;
      rsp_if.ready  = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      idle_en       = 1'b0;
      stall_left    = 0;
   end

   // Response side: random stall bursts while idling is enabled, otherwise
   // ready once any running burst has ended.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         stall_left   <= $urandom_range(0, 15);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Generous ceiling on the length of the run.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Present one access beat and hold it until accepted. Valid stays high
   // on return so back-to-back beats never toggle it within a time step.
   task automatic send_key(input logic [KEY_W-1:0] key);
      int gap;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         gap          = $urandom_range(1, 16);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.key   <= key;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Stop sending and wait until every outstanding beat has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Size changes only with the pipe empty.
   task automatic set_size(input logic [CFG_W-1:0] sz);
      drain();
      repeat (DRAIN_GAP) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= sz;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [KEY_W-1:0] key_pool [POOL_SIZE];
      logic [KEY_W-1:0] ka, kb, kc, kd, key;
      logic [CFG_W-1:0] sz;
      int               sent, n, eff, wset;

      foreach (key_pool[i])
         key_pool[i] = {$urandom, $urandom};
      ka = {$urandom, $urandom};
      kb = {$urandom, $urandom};
      kc = {$urandom, $urandom};
      kd = {$urandom, $urandom};
      sz = SIZE_OFF;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // Size is zero out of reset: every access misses, nothing is stored.
      send_key('0);
      send_key('1);
      send_key('0);

      // Two entries: hit promotion, eviction of the least recently used,
      // a re-miss on the evicted key, then a hit on a survivor.
      set_size(6'd2);
      send_key(ka);
      send_key(ka);
      send_key(kb);
      send_key(kc);   // evicts ka
      send_key(ka);   // miss, evicts kb
      send_key(kc);   // hit

      // Register value above capacity behaves as full capacity.
      set_size(SIZE_TOP);
      send_key('0);
      send_key('1);
      send_key('0);   // hit on the all-zero key

      // Shrink below occupancy: hits still search every valid entry, the
      // next miss evicts down to the new size before inserting.
      set_size(SIZE_ONE);
      send_key(ka);
      send_key(kd);

      // Size zero with live entries: miss, contents and occupancy unchanged.
      set_size(SIZE_OFF);
      send_key(kd);
      send_key(kc);

      // ---- random part ----
      // Phases of random length, each with its own size and working set.
      // Most keys come from a shared pool so the contents persist across
      // size changes; a tenth are fresh random keys. The calm tail keeps
      // the last size so the stream runs without pauses.
      sent = 0;
      while (sent < RAND_ITEMS) begin
         if (sent < RAND_ITEMS - CALM_ITEMS) begin
            case ($urandom_range(0, 9))
               0:       sz = SIZE_OFF;
               1:       sz = SIZE_ONE;
               2:       sz = SIZE_FULL;
               3:       sz = ($urandom_range(0, 1) != 0) ? SIZE_OVER : SIZE_TOP;
               default: sz = CFG_W'($urandom_range(1, 32));
            endcase
            set_size(sz);
         end
         idle_en = (sent < RAND_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);

         repeat (3)
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};

         // working set around the effective size: below it gives mostly
         // hits, above it keeps the eviction path busy
         eff = (sz > SIZE_FULL) ? 32 : int'(sz);
         if (eff == 0)
            wset = 8;
         else if ($urandom_range(0, 2) == 0)
            wset = (eff > 1) ? eff / 2 : 1;
         else
            wset = eff + $urandom_range(0, 6);
         if (wset > POOL_SIZE)
            wset = POOL_SIZE;

         n = $urandom_range(30, 120);
         for (int k = 0; k < n && sent < RAND_ITEMS; k++) begin
            if ($urandom_range(0, 9) == 0)
               key = {$urandom, $urandom};
            else
               key = key_pool[$urandom_range(0, wset - 1)];
            send_key(key);
            sent++;
            if (sent >= RAND_ITEMS - CALM_ITEMS)
               idle_en = 1'b0;
            // occasional mid-phase pause until everything has come back
            if (sent < RAND_ITEMS - CALM_ITEMS && $urandom_range(0, 63) == 0)
               drain();
         end
      end

      // ---- wrap-up ----
      drain();
      repeat (DRAIN_GAP * 2) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
